FILE: design/nfpa_pkg.sv
// Shared types and codes for the next-fit pool allocator.
// Used by the controller, the datapath and the top level.
package nfpa_pkg;

	localparam int CNT_BITS = 6;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_STATS = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ASCAN,
		ST_FSCAN,
		ST_FMARK,
		ST_FPREV,
		ST_FNEXT,
		ST_SBEGIN,
		ST_STATS,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_ASTEP,
		DP_ATAKE,
		DP_FSTEP,
		DP_FMARK,
		DP_PMERGE,
		DP_PSKIP,
		DP_NMERGE,
		DP_SBEGIN,
		DP_SSTEP,
		DP_PUSH
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] in_op;
		logic       amount_zero;
		logic       hit_alloc;
		logic       hit_free;
		logic       n_last;
		logic       ptr_last;
		logic       need_split;
		logic       table_full;
		logic       ptr_zero;
		logic       prev_free;
		logic       next_free;
		logic       out_free;
	} dp_status_t;

endpackage

FILE: design/nfpa_ctrl.sv
// Controller state machine of the next-fit pool allocator.
// Depends on nfpa_pkg; drives datapath commands from datapath status.
module nfpa_ctrl
	import nfpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       cfg_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = DP_NOP;
		s_tready  = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				cfg_ready = !s_tvalid;
				if (s_tvalid) begin
					cmd = DP_LOAD;
					unique case (status.in_op)
						OP_ALLOC: state_d = status.amount_zero ? ST_SBEGIN : ST_ASCAN;
						OP_FREE:  state_d = ST_FSCAN;
						default:  state_d = ST_SBEGIN;
					endcase
				end
			end
			ST_ASCAN: begin
				if (status.hit_alloc) begin
					if (!(status.need_split && status.table_full)) begin
						cmd = DP_ATAKE;
					end
					state_d = ST_SBEGIN;
				end else if (status.n_last) begin
					state_d = ST_SBEGIN;
				end else begin
					cmd = DP_ASTEP;
				end
			end
			ST_FSCAN: begin
				if (status.hit_free) begin
					state_d = ST_FMARK;
				end else if (status.ptr_last) begin
					state_d = ST_SBEGIN;
				end else begin
					cmd = DP_FSTEP;
				end
			end
			ST_FMARK: begin
				cmd     = DP_FMARK;
				state_d = status.ptr_zero ? ST_FNEXT : ST_FPREV;
			end
			ST_FPREV: begin
				cmd     = status.prev_free ? DP_PMERGE : DP_PSKIP;
				state_d = ST_FNEXT;
			end
			ST_FNEXT: begin
				if (status.next_free) begin
					cmd = DP_NMERGE;
				end
				state_d = ST_SBEGIN;
			end
			ST_SBEGIN: begin
				cmd     = DP_SBEGIN;
				state_d = ST_STATS;
			end
			ST_STATS: begin
				cmd = DP_SSTEP;
				if (status.ptr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd     = DP_PUSH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: design/nfpa_datapath.sv
// Datapath of the next-fit pool allocator: segment table, rover, scan pointer,
// statistics accumulators and output register. Depends on nfpa_pkg.
module nfpa_datapath
	import nfpa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 32,
	parameter int ADDR_BITS    = 16,
	parameter int IN_W         = 40,
	parameter int OUT_W        = 80
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IN_W-1:0]      s_tdata,
	input  logic                 cfg_fire,
	input  logic [ADDR_BITS-1:0] cfg_data,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int A  = ADDR_BITS;

	logic [A-1:0]            start_q [MAX_SEGMENTS];
	logic [A-1:0]            len_q   [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] used_q;
	logic [CW-1:0]           count_q, ptr_q, n_q;
	logic [IW-1:0]           rover_q;

	logic [A-1:0]        amount_q, address_q, len_a_q, where_q;
	logic                ok_q;
	logic [A-1:0]        free_q, usedb_q, run_q, largest_q;
	logic [CNT_BITS-1:0] holes_q, small_q;
	logic                seen_q, isal_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic [1:0]    in_op;
	logic [A-1:0]  in_amount, in_address;
	logic [IW-1:0] pi;
	logic [A-1:0]  rd_start, rd_len, sum_len, run_n;
	logic          rd_used;
	logic [CW-1:0] ptr_inc, count_m1, merge_k, merge_km1;
	logic          ptr_lt_count;
	logic [OUT_W-1:0] pack;

	assign in_op      = s_tdata[1:0];
	assign in_amount  = s_tdata[2 +: A];
	assign in_address = s_tdata[2 + A +: A];

	assign pi           = ptr_q[IW-1:0];
	assign rd_start     = start_q[pi];
	assign rd_len       = len_q[pi];
	assign rd_used      = used_q[pi];
	assign ptr_inc      = ptr_q + 1'b1;
	assign count_m1     = count_q - 1'b1;
	assign ptr_lt_count = ptr_q < count_q;
	assign sum_len      = len_a_q + rd_len;
	assign run_n        = run_q + rd_len;
	assign merge_k      = (cmd == DP_PMERGE) ? ptr_inc : ptr_q;
	assign merge_km1    = merge_k - 1'b1;

	always_comb begin
		status.in_op       = in_op;
		status.amount_zero = (in_amount == '0);
		status.hit_alloc   = !rd_used && (rd_len >= amount_q);
		status.hit_free    = (rd_start == address_q);
		status.n_last      = (n_q == count_m1);
		status.ptr_last    = (ptr_q == count_m1);
		status.need_split  = (rd_len > amount_q);
		status.table_full  = (count_q >= CW'(MAX_SEGMENTS));
		status.ptr_zero    = (ptr_q == '0);
		status.prev_free   = !rd_used;
		status.next_free   = ptr_lt_count && !rd_used;
		status.out_free    = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_SEGMENTS; j++) begin
				start_q[j] <= '0;
				len_q[j]   <= '0;
			end
			used_q    <= '0;
			count_q   <= CW'(1);
			rover_q   <= '0;
			ptr_q     <= '0;
			n_q       <= '0;
			ok_q      <= 1'b0;
			amount_q  <= '0;
			address_q <= '0;
			len_a_q   <= '0;
			where_q   <= '0;
			free_q    <= '0;
			usedb_q   <= '0;
			run_q     <= '0;
			largest_q <= '0;
			holes_q   <= '0;
			small_q   <= '0;
			seen_q    <= 1'b0;
			isal_q    <= 1'b0;
		end else if (cfg_fire) begin
			for (int j = 0; j < MAX_SEGMENTS; j++) begin
				start_q[j] <= '0;
				len_q[j]   <= (j == 0) ? cfg_data : '0;
			end
			used_q   <= '0;
			count_q  <= CW'(1);
			rover_q  <= '0;
		end else begin
			case (cmd)
				DP_LOAD: begin
					amount_q  <= in_amount;
					address_q <= in_address;
					ok_q      <= (in_op == OP_STATS);
					where_q   <= '0;
					n_q       <= '0;
					if (in_op == OP_ALLOC && CW'(rover_q) < count_q) begin
						ptr_q <= CW'(rover_q);
					end else begin
						ptr_q <= '0;
					end
				end
				DP_ASTEP: begin
					n_q   <= n_q + 1'b1;
					ptr_q <= (ptr_inc < count_q) ? ptr_inc : '0;
				end
				DP_ATAKE: begin
					ok_q       <= 1'b1;
					where_q    <= rd_start;
					used_q[pi] <= 1'b1;
					if (rd_len > amount_q) begin
						for (int j = 1; j < MAX_SEGMENTS; j++) begin
							if (CW'(j) > ptr_inc && CW'(j) <= count_q) begin
								start_q[j]  <= start_q[j-1];
								len_q[j]    <= len_q[j-1];
								used_q[j]   <= used_q[j-1];
							end else if (CW'(j) == ptr_inc) begin
								start_q[j] <= rd_start + amount_q;
								len_q[j]   <= rd_len - amount_q;
								used_q[j]  <= 1'b0;
							end
						end
						len_q[pi] <= amount_q;
						count_q   <= count_q + 1'b1;
						rover_q   <= ptr_inc[IW-1:0];
					end else begin
						rover_q <= (ptr_inc < count_q) ? ptr_inc[IW-1:0] : '0;
					end
				end
				DP_FSTEP: begin
					ptr_q <= ptr_inc;
				end
				DP_FMARK: begin
					used_q[pi] <= 1'b0;
					ok_q       <= 1'b1;
					len_a_q    <= rd_len;
					ptr_q      <= (ptr_q == '0) ? ptr_inc : ptr_q - 1'b1;
				end
				DP_PMERGE, DP_NMERGE: begin
					len_q[merge_km1[IW-1:0]] <= sum_len;
					for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
						if (CW'(j) >= merge_k && CW'(j) + 1'b1 < count_q) begin
							start_q[j] <= start_q[j+1];
							len_q[j]   <= len_q[j+1];
							used_q[j]  <= used_q[j+1];
						end
					end
					count_q <= count_m1;
					if (CW'(rover_q) == merge_k) begin
						rover_q <= (merge_k + 1'b1 == count_q) ? '0 : merge_km1[IW-1:0];
					end else if (CW'(rover_q) > merge_k) begin
						rover_q <= rover_q - 1'b1;
					end
					if (cmd == DP_PMERGE) begin
						len_a_q <= sum_len;
						ptr_q   <= ptr_inc;
					end
				end
				DP_PSKIP: begin
					ptr_q <= ptr_q + CW'(2);
				end
				DP_SBEGIN: begin
					ptr_q     <= '0;
					free_q    <= '0;
					usedb_q   <= '0;
					run_q     <= '0;
					largest_q <= '0;
					holes_q   <= '0;
					small_q   <= '0;
					seen_q    <= 1'b0;
					isal_q    <= 1'b0;
				end
				DP_SSTEP: begin
					ptr_q <= ptr_inc;
					if (!seen_q && rd_start == address_q) begin
						seen_q <= 1'b1;
						isal_q <= rd_used;
					end
					if (rd_used) begin
						usedb_q <= usedb_q + rd_len;
						run_q   <= '0;
					end else begin
						free_q  <= free_q + rd_len;
						holes_q <= holes_q + 1'b1;
						if (rd_len < amount_q) begin
							small_q <= small_q + 1'b1;
						end
						run_q <= run_n;
						if (run_n > largest_q) begin
							largest_q <= run_n;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		pack                              = '0;
		pack[0]                           = ok_q;
		pack[1 +: A]                      = where_q;
		pack[1 + A]                       = isal_q;
		pack[2 + A +: A]                  = free_q;
		pack[2 + 2*A +: A]                = usedb_q;
		pack[2 + 3*A +: CNT_BITS]         = holes_q;
		pack[2 + 3*A + CNT_BITS +: A]     = largest_q;
		pack[2 + 4*A + CNT_BITS +: CNT_BITS] = small_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd == DP_PUSH) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == DP_PUSH) begin
			m_tdata_q <= pack;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: design/next_fit_pool_allocator.sv
// Next-fit pool allocator, top level: controller plus datapath.
// Items are handled one at a time: a new input transaction is taken only in the idle state,
// after the previous result has been pushed. The table is scanned one entry per cycle.
// Reset leaves one free segment of size 0.
// Writing pool_size resets the table to one free segment.
module next_fit_pool_allocator
	import nfpa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 32,
	parameter int ADDR_BITS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// operation, amount, address
	input  logic [((2 + 2*ADDR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// ok, alloc_address, is_allocated, free_bytes, allocated_bytes, hole_count,
	// largest_free, small_free_count
	output logic [((14 + 4*ADDR_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ADDR_BITS-1:0]   cfg_data
);

	localparam int IN_W  = ((2 + 2*ADDR_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((14 + 4*ADDR_BITS + 7) / 8) * 8;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_fire;

	assign cfg_fire = cfg_valid && cfg_ready;

	nfpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	nfpa_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_BITS    (ADDR_BITS),
		.IN_W         (IN_W),
		.OUT_W        (OUT_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg_fire (cfg_fire),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: design/nfpa_checker.sv
// Port-level checks for the next-fit pool allocator, bound to the top level.
// Depends only on the top-level ports.
module nfpa_checker #(
	parameter int ADDR_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [((14 + 4*ADDR_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !cfg_ready)
		else $error("input taken while a transaction is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || m_tdata[ADDR_BITS:1] == '0))
		else $error("failed transaction reports nonzero address");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> s_tready)
		else $error("block busy after configuration write");

endmodule

bind next_fit_pool_allocator nfpa_checker #(.ADDR_BITS(ADDR_BITS)) u_nfpa_checker (.*);

FILE: dv/testbench.sv
// Self-checking bench for the next-fit pool allocator: a directed table, then random
// allocate, free and query traffic with stalls, all checked against an in-bench model.
// Depends on nfpa_pkg and next_fit_pool_allocator.
`timescale 1ns / 100ps

module testbench;
	import nfpa_pkg::*;

	localparam int NSEG = 32;
	localparam logic [1:0] OP_BAD = 2'd3;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [5:0]  small_cnt;
		logic [15:0] largest;
		logic [5:0]  holes;
		logic [15:0] used_b;
		logic [15:0] free_b;
		logic        is_alloc;
		logic [15:0] where;
		logic        ok;
	} result_t;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] amount;
		logic [15:0] addr;
		bit          typed;
		result_t     want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [79:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	next_fit_pool_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	logic [15:0] seg_base [NSEG];
	logic [15:0] seg_len [NSEG];
	bit seg_busy [NSEG];
	int seg_n, rover;
	logic [15:0] pool_bytes;
	result_t pending_results [$];
	int errors = 0, cycles = 0, n_items = 0, n_results = 0;

	function automatic void pool_clear();
		for (int i = 0; i < NSEG; i++) begin
			seg_base[i] = 0; seg_len[i] = 0; seg_busy[i] = 0;
		end
		seg_len[0] = pool_bytes;
		seg_n = 1;
		rover = 0;
	endfunction

	function automatic void merge_down(int k);
		bit was_last;
		was_last = (k + 1 == seg_n);
		seg_len[k-1] = seg_len[k-1] + seg_len[k];
		for (int j = k; j + 1 < seg_n; j++) begin
			seg_base[j] = seg_base[j+1]; seg_len[j] = seg_len[j+1]; seg_busy[j] = seg_busy[j+1];
		end
		seg_n--;
		if (rover == k) rover = was_last ? 0 : k - 1;
		else if (rover > k) rover--;
	endfunction

	function automatic bit pool_alloc(logic [15:0] amount, output logic [15:0] where);
		int idx;
		bit found;
		where = 0;
		found = 0;
		if (amount == 0) return 0;
		idx = rover < seg_n ? rover : 0;
		for (int n = 0; n < seg_n; n++) begin
			if (!seg_busy[idx] && seg_len[idx] >= amount) begin
				found = 1;
				break;
			end
			idx = (idx + 1 < seg_n) ? idx + 1 : 0;
		end
		if (!found) return 0;
		if (seg_len[idx] > amount) begin
			if (seg_n >= NSEG) return 0;
			for (int j = seg_n; j > idx + 1; j--) begin
				seg_base[j] = seg_base[j-1]; seg_len[j] = seg_len[j-1]; seg_busy[j] = seg_busy[j-1];
			end
			seg_base[idx+1] = seg_base[idx] + amount;
			seg_len[idx+1] = seg_len[idx] - amount;
			seg_busy[idx+1] = 0;
			seg_len[idx] = amount;
			seg_n++;
		end
		seg_busy[idx] = 1;
		rover = (idx + 1 < seg_n) ? idx + 1 : 0;
		where = seg_base[idx];
		return 1;
	endfunction

	function automatic bit pool_free(logic [15:0] addr);
		int idx;
		idx = -1;
		for (int i = 0; i < seg_n; i++)
			if (seg_base[i] == addr) begin
				idx = i;
				break;
			end
		if (idx < 0) return 0;
		seg_busy[idx] = 0;
		if (idx > 0 && !seg_busy[idx-1]) begin
			merge_down(idx);
			idx--;
		end
		if (idx + 1 < seg_n && !seg_busy[idx+1]) merge_down(idx + 1);
		return 1;
	endfunction

	function automatic result_t pool_step(logic [1:0] op, logic [15:0] amount,
			logic [15:0] addr);
		result_t r;
		logic [15:0] where;
		longint run, best, fsum, usum;
		int holes, smalls;
		bit seen;
		r = '0; where = 0; run = 0; best = 0; fsum = 0; usum = 0;
		holes = 0; smalls = 0; seen = 0;
		case (op)
			OP_ALLOC: r.ok = pool_alloc(amount, where);
			OP_FREE:  r.ok = pool_free(addr);
			OP_STATS: r.ok = 1;
			default:  r.ok = 0;
		endcase
		r.where = r.ok ? where : 16'd0;
		for (int i = 0; i < seg_n; i++) begin
			if (!seen && seg_base[i] == addr) begin
				seen = 1;
				r.is_alloc = seg_busy[i];
			end
			if (seg_busy[i]) begin
				usum += seg_len[i];
				run = 0;
			end else begin
				fsum += seg_len[i];
				holes++;
				if (seg_len[i] < amount) smalls++;
				run += seg_len[i];
				if (run > best) best = run;
			end
		end
		r.free_b = fsum[15:0];
		r.used_b = usum[15:0];
		r.holes = holes[5:0];
		r.largest = best[15:0];
		r.small_cnt = smalls[5:0];
		return r;
	endfunction

	function automatic int stall_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// check each result transaction against the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[77:0];
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					$display("  ok %0d/%0d where %0d/%0d isal %0d/%0d free %0d/%0d used %0d/%0d",
						want.ok, got.ok, want.where, got.where, want.is_alloc, got.is_alloc,
						want.free_b, got.free_b, want.used_b, got.used_b);
					$display("  holes %0d/%0d largest %0d/%0d small %0d/%0d",
						want.holes, got.holes, want.largest, got.largest,
						want.small_cnt, got.small_cnt);
				end
			end
		end
	end

	bit quiet_sink = 0;
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet_sink) begin
				m_tready <= 1;
			end else begin
				k = stall_len();
				if (k == 0) m_tready <= 1;
				else begin
					m_tready <= 0;
					repeat (k) @(negedge clk);
					m_tready <= 1;
				end
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic [15:0] amount, logic [15:0] addr,
			bit typed, result_t want, bit gaps);
		result_t model_r;
		int k;
		k = gaps ? stall_len() : 0;
		if (k > 0) begin
			s_tvalid <= 0;
			repeat (k) @(negedge clk);
		end
		model_r = pool_step(op, amount, addr);
		if (typed && model_r !== want) begin
			$display("%0t: table row disagrees with prediction: expected %h actual %h",
				$time, want, model_r);
			errors++;
		end
		pending_results.push_back(model_r);
		s_tdata <= {6'd0, addr, amount, op};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_items++;
		@(negedge clk);
	endtask

	task automatic write_pool(logic [15:0] size);
		s_tvalid <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_data <= size;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		pool_bytes = size;
		pool_clear();
	endtask

	function automatic result_t res(bit ok, int where, bit isal, int fb, int ub, int h,
			int lg, int sm);
		result_t r;
		r.ok = ok; r.where = 16'(where); r.is_alloc = isal; r.free_b = 16'(fb);
		r.used_b = 16'(ub); r.holes = 6'(h); r.largest = 16'(lg); r.small_cnt = 6'(sm);
		return r;
	endfunction

	initial begin
		row_t rows [$];
		logic [1:0] op;
		logic [15:0] amount, addr, sizes [5];
		int pick;
		pool_bytes = 0;
		pool_clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// after reset: pool of zero bytes
		rows.push_back('{OP_STATS, 16'd0, 16'd0, 1, res(1, 0, 0, 0, 0, 1, 0, 0)});
		rows.push_back('{OP_ALLOC, 16'd1, 16'd0, 1, res(0, 0, 0, 0, 0, 1, 0, 1)});
		rows.push_back('{OP_BAD, 16'hFFFF, 16'hFFFF, 1, res(0, 0, 0, 0, 0, 1, 0, 1)});
		foreach (rows[i])
			send_item(rows[i].op, rows[i].amount, rows[i].addr, rows[i].typed, rows[i].want, 0);
		rows.delete();

		write_pool(16'hFFFF);
		rows.push_back('{OP_ALLOC, 16'd0, 16'd0, 1, res(0, 0, 0, 65535, 0, 1, 65535, 0)});
		rows.push_back('{OP_ALLOC, 16'd100, 16'd0, 1, res(1, 0, 1, 65435, 100, 1, 65435, 0)});
		rows.push_back('{OP_ALLOC, 16'hFFFF, 16'd0, 1, res(0, 0, 1, 65435, 100, 1, 65435, 1)});
		rows.push_back('{OP_ALLOC, 16'd200, 16'd100, 0, '0});
		rows.push_back('{OP_ALLOC, 16'd50, 16'd300, 0, '0});
		rows.push_back('{OP_FREE, 16'd0, 16'd1234, 1, res(0, 0, 0, 65185, 350, 1, 65185, 0)});
		rows.push_back('{OP_FREE, 16'd0, 16'd100, 0, '0});
		rows.push_back('{OP_FREE, 16'd0, 16'd100, 0, '0});
		rows.push_back('{OP_FREE, 16'd300, 16'd0, 0, '0});
		rows.push_back('{OP_FREE, 16'd0, 16'd300, 0, '0});
		rows.push_back('{OP_STATS, 16'hFFFF, 16'hFFFF, 0, '0});
		rows.push_back('{OP_ALLOC, 16'd65535, 16'd0, 1, res(1, 0, 1, 0, 65535, 0, 0, 0)});
		rows.push_back('{OP_FREE, 16'd0, 16'd0, 1, res(1, 0, 0, 65535, 0, 1, 65535, 0)});
		foreach (rows[i])
			send_item(rows[i].op, rows[i].amount, rows[i].addr, rows[i].typed, rows[i].want, 0);

		// fill the table to its limit with one-byte pieces
		write_pool(16'd40);
		for (int i = 0; i < 34; i++) send_item(OP_ALLOC, 16'd1, 16'd0, 0, '0, 1);
		send_item(OP_STATS, 16'd2, 16'd31, 0, '0, 1);

		sizes = '{16'd0, 16'd1, 16'd300, 16'd4096, 16'hFFFF};
		for (int ph = 0; ph < 5; ph++) begin
			write_pool(ph == 0 ? 16'd0 : ($urandom_range(0, 1) ? sizes[ph] : 16'($urandom)));
			quiet_sink = (ph == 2);
			for (int i = 0; i < 280; i++) begin
				pick = $urandom_range(0, 99);
				addr = 16'($urandom);
				amount = 16'($urandom);
				if (pick < 45) begin
					op = OP_ALLOC;
					if ($urandom_range(0, 9) != 0 && pool_bytes > 0)
						amount = 16'($urandom_range(1, (pool_bytes >> 3) + 1));
				end else if (pick < 85) begin
					op = OP_FREE;
					if ($urandom_range(0, 7) != 0 && seg_n > 0)
						addr = seg_base[$urandom_range(0, seg_n - 1)];
					if ($urandom_range(0, 1)) amount = 16'($urandom_range(0, 64));
				end else if (pick < 97) begin
					op = OP_STATS;
					if ($urandom_range(0, 1)) addr = seg_base[$urandom_range(0, seg_n - 1)];
				end else op = OP_BAD;
				send_item(op, amount, addr, 0, '0, 1);
			end
		end
		quiet_sink = 0;
		s_tvalid <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("Ran %0d requests (allocate, free, query, unused code) over 7 pool sizes;",
			n_items);
		$display("checked %0d results, including table-full and zero-size cases.", n_results);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
